/* hw/rtl/bae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the barometric altitude estimator.
// ----------------------------------------------------------------------------
package bae_pkg;

    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int PRES_W = 17;
    localparam int GND_W  = 23;
    localparam int ALT_W  = 21;
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 24;
    localparam int CFG_IDX_W   = 3;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;

    // Wide compensation terms
    localparam int CMP_W = 42;
    localparam int ACC_W = 64;

    // Reciprocal scaling for division by a small constant
    localparam int DIV_SHIFT = 25;
    localparam int DIV_W     = 25;

    localparam int           PRES_MAX  = 131071;
    localparam int           HEIGHT_K  = 2132;
    localparam logic signed [19:0] TEMP_REF = 20'sd2000;
    localparam logic signed [19:0] TEMP_LOW = -20'sd1500;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SENS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TCS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TCO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TREF     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_TEMPSENS = 3'd5;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] tcs;
        logic [CAL_W-1:0] tco;
        logic [CAL_W-1:0] tref;
        logic [CAL_W-1:0] tempsens;
    } cal_t;

    // What the back end does with an item's pressure
    typedef enum logic [1:0] {
        KIND_ACCUM,
        KIND_MEAN,
        KIND_ALT
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT,
        ST_MT,
        ST_TEMP,
        ST_OFF,
        ST_SENS,
        ST_SQ,
        ST_SQ2,
        ST_CORR,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_PT,
        ST_PSAT,
        ST_APPLY,
        ST_HGT,
        ST_FMUL,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } bae_state_t;

endpackage

/* hw/rtl/bae_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bae_front
// Accepts items, tags each with its role (ground sum, ground mean, altitude)
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bae_front #(
    parameter int GROUND_SAMPLES = 50
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bae_pkg::TDATA_IN_W-1:0]   s_tdata,
    output logic                             q_valid,
    output bae_pkg::item_t                   q_item,
    input  logic                             q_pop
);
    import bae_pkg::*;

    localparam int CNT_W = $clog2(GROUND_SAMPLES + 2);
    localparam logic [CNT_W-1:0] CNT_MEAN = CNT_W'(GROUND_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_ALT  = CNT_W'(GROUND_SAMPLES + 1);

    item_t            mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    kind_t            kind;

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // Classify by how many items came before
    always_comb begin
        if (cnt_reg < CNT_MEAN) begin
            kind = KIND_ACCUM;
        end else if (cnt_reg == CNT_MEAN) begin
            kind = KIND_MEAN;
        end else begin
            kind = KIND_ALT;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{kind: kind,
                                     raw_pressure: s_tdata[RAW_W-1:0],
                                     raw_temperature: s_tdata[2*RAW_W-1:RAW_W]};
        end
    end

    // Pointers, fill level and item counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
                if (cnt_reg != CNT_ALT) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (!push && q_pop) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/bae_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bae_back
// Sequencer around one shared 27x27 multiplier: pressure compensation,
// ground mean, height and moving-average filter, with an output register.
// ----------------------------------------------------------------------------
module bae_back #(
    parameter int GROUND_SAMPLES = 50,
    parameter int FILTER_TAPS    = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bae_pkg::cal_t                     cal,
    input  logic                              q_valid,
    input  bae_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bae_pkg::TDATA_OUT_W-1:0]   m_tdata
);
    import bae_pkg::*;

    localparam int SUM_W = ALT_W + $clog2(FILTER_TAPS);
    localparam logic [DIV_W-1:0] HALF_G = DIV_W'(GROUND_SAMPLES / 2);
    localparam logic [DIV_W-1:0] N_G    = DIV_W'(GROUND_SAMPLES);
    localparam logic [DIV_W-1:0] N_F    = DIV_W'(FILTER_TAPS);
    localparam logic signed [MUL_W-1:0] RECIP_G = MUL_W'((1 << DIV_SHIFT) / GROUND_SAMPLES);
    localparam logic signed [MUL_W-1:0] RECIP_F = MUL_W'((1 << DIV_SHIFT) / FILTER_TAPS);

    bae_state_t state_reg, state_next;

    item_t                     item_reg;
    logic signed [24:0]        dt_reg;
    logic signed [19:0]        temp_reg;
    logic signed [CMP_W-1:0]   off_reg;
    logic signed [CMP_W-1:0]   sens_reg;
    logic [CMP_W-1:0]          off2_reg;
    logic [CMP_W-1:0]          sens2_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   t_reg;
    logic [PRES_W-1:0]         p_reg;
    logic [GND_W-1:0]          ground_reg;
    logic [ALT_W-1:0]          win_reg [FILTER_TAPS];
    logic [SUM_W-1:0]          sum_reg;
    logic [DIV_W-1:0]          x_reg;
    logic [DIV_W-1:0]          q0_reg;
    logic [DIV_W-1:0]          r_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      m_valid_reg;
    logic [ALT_W-1:0]          m_data_reg;
    logic [ALT_W-1:0]          res_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [19:0]        d_val, e_val;
    logic [CMP_W-1:0]          sq;
    logic signed [ACC_W-1:0]   t_sh;
    logic [ALT_W-1:0]          h_val;
    logic [DIV_W-1:0]          div_n;
    logic [GND_W-1:0]          diff;
    logic                      out_free;

    assign d_val    = temp_reg - TEMP_REF;
    assign e_val    = temp_reg - TEMP_LOW;
    assign sq       = CMP_W'(prod_reg);
    assign t_sh     = t_reg >>> 15;
    assign h_val    = prod_reg[ALT_W+7:8];
    assign div_n    = (item_reg.kind == KIND_MEAN) ? N_G : N_F;
    assign diff     = ground_reg - GND_W'(p_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(m_data_reg);

    // Next state and multiplier operand selection
    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = ST_DT;
                end
            end
            ST_DT:   state_next = ST_MT;
            ST_MT: begin
                mul_a      = MUL_W'(dt_reg);
                mul_b      = MUL_W'({1'b0, cal.tempsens});
                state_next = ST_TEMP;
            end
            ST_TEMP: begin
                mul_a      = MUL_W'(dt_reg);
                mul_b      = MUL_W'({1'b0, cal.tco});
                state_next = ST_OFF;
            end
            ST_OFF: begin
                mul_a      = MUL_W'(dt_reg);
                mul_b      = MUL_W'({1'b0, cal.tcs});
                state_next = ST_SENS;
            end
            ST_SENS: begin
                mul_a      = MUL_W'(d_val);
                mul_b      = MUL_W'(d_val);
                state_next = ST_SQ;
            end
            ST_SQ: begin
                mul_a      = MUL_W'(e_val);
                mul_b      = MUL_W'(e_val);
                state_next = ST_SQ2;
            end
            ST_SQ2:  state_next = ST_CORR;
            ST_CORR: state_next = ST_P1;
            ST_P1: begin
                mul_a      = MUL_W'({1'b0, sens_reg[23:0]});
                mul_b      = MUL_W'({1'b0, item_reg.raw_pressure});
                state_next = ST_P2;
            end
            ST_P2: begin
                // upper part of SENS carries the sign
                mul_a      = MUL_W'($signed(sens_reg[CMP_W-1:24]));
                mul_b      = MUL_W'({1'b0, item_reg.raw_pressure});
                state_next = ST_P3;
            end
            ST_P3:   state_next = ST_PT;
            ST_PT:   state_next = ST_PSAT;
            ST_PSAT: state_next = ST_APPLY;
            ST_APPLY: begin
                case (item_reg.kind)
                    KIND_ACCUM: state_next = ST_IDLE;
                    KIND_MEAN: begin
                        mul_a      = MUL_W'({1'b0, DIV_W'(ground_reg) + HALF_G});
                        mul_b      = RECIP_G;
                        state_next = ST_DIV1;
                    end
                    default: begin
                        mul_a      = (ground_reg > GND_W'(p_reg)) ?
                                     MUL_W'({1'b0, diff}) : '0;
                        mul_b      = MUL_W'(HEIGHT_K);
                        state_next = ST_HGT;
                    end
                endcase
            end
            ST_HGT:  state_next = ST_FMUL;
            ST_FMUL: begin
                mul_a      = MUL_W'({1'b0, sum_reg});
                mul_b      = RECIP_F;
                state_next = ST_DIV1;
            end
            ST_DIV1: state_next = ST_DIV2;
            ST_DIV2: begin
                state_next = (item_reg.kind == KIND_MEAN) ? ST_IDLE : ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Shared multiplier, product registered
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Compensation datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                item_reg <= q_item;
            end
            ST_DT: begin
                dt_reg <= $signed({1'b0, item_reg.raw_temperature})
                          - $signed({1'b0, cal.tref, 8'h00});
            end
            ST_TEMP: begin
                temp_reg <= TEMP_REF + 20'(prod_reg >>> 23);
            end
            ST_OFF: begin
                off_reg <= $signed(CMP_W'({cal.offset, 16'h0000})) + CMP_W'(prod_reg >>> 7);
            end
            ST_SENS: begin
                sens_reg <= $signed(CMP_W'({cal.sens, 15'h0000})) + CMP_W'(prod_reg >>> 8);
            end
            ST_SQ: begin
                off2_reg  <= (sq + (sq << 2)) >> 1;
                sens2_reg <= (sq + (sq << 2)) >> 2;
            end
            ST_SQ2: begin
                if (temp_reg < TEMP_LOW) begin
                    off2_reg  <= off2_reg + ((sq << 3) - sq);
                    sens2_reg <= sens2_reg + (((sq << 3) + (sq << 1) + sq) >> 1);
                end
            end
            ST_CORR: begin
                if (temp_reg < TEMP_REF) begin
                    off_reg  <= off_reg - $signed(off2_reg);
                    sens_reg <= sens_reg - $signed(sens2_reg);
                end
            end
            ST_P2: begin
                acc_reg <= ACC_W'(prod_reg);
            end
            ST_P3: begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< 24);
            end
            ST_PT: begin
                t_reg <= (acc_reg >>> 21) - ACC_W'(off_reg);
            end
            ST_PSAT: begin
                if (t_sh < 0) begin
                    p_reg <= '0;
                end else if (t_sh > PRES_MAX) begin
                    p_reg <= PRES_W'(PRES_MAX);
                end else begin
                    p_reg <= t_sh[PRES_W-1:0];
                end
            end
            ST_APPLY: begin
                x_reg <= DIV_W'(ground_reg) + HALF_G;
            end
            ST_FMUL: begin
                x_reg <= DIV_W'(sum_reg);
            end
            ST_DIV1: begin
                q0_reg <= DIV_W'(prod_reg >>> DIV_SHIFT);
                r_reg  <= x_reg - DIV_W'(DIV_W'(prod_reg >>> DIV_SHIFT) * div_n);
            end
            ST_DIV2: begin
                res_reg <= ALT_W'(q0_reg + ((r_reg >= div_n) ? 1'b1 : 1'b0));
            end
            default: ;
        endcase
    end

    // Ground level, filter window and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ground_reg  <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < FILTER_TAPS; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (state_reg == ST_APPLY && item_reg.kind == KIND_ACCUM) begin
                ground_reg <= ground_reg + GND_W'(p_reg);
            end
            if (state_reg == ST_DIV2 && item_reg.kind == KIND_MEAN) begin
                ground_reg <= GND_W'(q0_reg + ((r_reg >= div_n) ? 1'b1 : 1'b0));
            end
            // Running sum: add newest height, drop oldest
            if (state_reg == ST_HGT) begin
                win_reg[0] <= h_val;
                for (int i = 1; i < FILTER_TAPS; i++) begin
                    win_reg[i] <= win_reg[i-1];
                end
                sum_reg <= sum_reg + SUM_W'(h_val) - SUM_W'(win_reg[FILTER_TAPS-1]);
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

endmodule

/* hw/rtl/baro_altitude_estimator_unit.sv */
`timescale 1ns / 1ps
// An accepted item waits in the two-entry front-end queue until the back end is
// idle and pops it; the back end then runs the item through its sequence of
// steps on the single shared 27x27 multiplier and takes no new item before it
// is done, an altitude item also waiting for the output register to be free.
// Reset (aresetn low, synchronous) clears calibration, ground sum, count,
// filter window, queue and output valid.
// ----------------------------------------------------------------------------
// baro_altitude_estimator_unit
// Barometer compensation, ground reference and filtered altitude, top level.
// ----------------------------------------------------------------------------
module baro_altitude_estimator_unit #(
    parameter int GROUND_SAMPLES = 50,
    parameter int FILTER_TAPS    = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [bae_pkg::TDATA_IN_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [20:0] altitude_cm, [23:21] zero
    output logic [bae_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bae_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bae_pkg::CAL_W-1:0]           cfg_data
);
    import bae_pkg::*;

    cal_t  cal_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    // Calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CAL_SENS:     cal_reg.sens     <= cfg_data;
                REG_CAL_OFFSET:   cal_reg.offset   <= cfg_data;
                REG_CAL_TCS:      cal_reg.tcs      <= cfg_data;
                REG_CAL_TCO:      cal_reg.tco      <= cfg_data;
                REG_CAL_TREF:     cal_reg.tref     <= cfg_data;
                REG_CAL_TEMPSENS: cal_reg.tempsens <= cfg_data;
                default: ;
            endcase
        end
    end

    bae_front #(
        .GROUND_SAMPLES(GROUND_SAMPLES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bae_back #(
        .GROUND_SAMPLES(GROUND_SAMPLES),
        .FILTER_TAPS   (FILTER_TAPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cal      (cal_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hw/rtl/bae_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bae_checker
// Port-level checks on the altitude estimator, bound to the top level.
// ----------------------------------------------------------------------------
module bae_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bae_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input logic                                cfg_valid,
    input logic                                cfg_ready
);
    import bae_pkg::*;

    // No result right out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Pad bits above the altitude stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TDATA_OUT_W-1:ALT_W] == '0)
        else $error("pad bits set");

    // Configuration writes never stall
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind baro_altitude_estimator_unit bae_checker u_bae_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

/* test/baro_altitude_estimator_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_altitude_estimator_unit_test
// Self-checking bench for the barometric altitude estimator. Raw pressure and
// temperature items go in over the input stream in random bursts. A predictor
// in the bench does the compensation, ground averaging and height filter, and
// each altitude item is compared with the oldest prediction. The calibration
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module baro_altitude_estimator_unit_test;
    import bae_pkg::*;

    localparam int N_GROUND   = 50;
    localparam int N_TAPS     = 5;
    localparam int TAIL_WAIT  = 40;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_CAP  = 600000;
    localparam int N_REGS     = 6;

    typedef struct {
        logic [RAW_W-1:0] d1;
        logic [RAW_W-1:0] d2;
    } raw_pair_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CAL_W-1:0]       cfg_data;

    // Predictor state
    logic [CAL_W-1:0] cal_regs [N_REGS];
    int               ground_count;
    bit               ground_done;
    logic [GND_W-1:0] ground_level;
    logic [ALT_W-1:0] height_taps [N_TAPS];
    logic [ALT_W-1:0] altitude_q [$];

    int  err_count;
    int  items_sent;
    int  alts_seen;
    int  burst_left;
    bit  hold_req;
    longint cycle_count;

    raw_pair_t directed_rows [$];

    baro_altitude_estimator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Compensated pressure in 0.01 mbar, saturated
    function automatic logic [PRES_W-1:0] comp_pressure(logic [RAW_W-1:0] d1,
                                                        logic [RAW_W-1:0] d2);
        longint dt, temp, off, sens, sq, sq2, off2, sens2, p;
        dt   = longint'(d2) - longint'(cal_regs[REG_CAL_TREF]) * 256;
        temp = 2000 + ((dt * longint'(cal_regs[REG_CAL_TEMPSENS])) >>> 23);
        off  = longint'(cal_regs[REG_CAL_OFFSET]) * 65536
             + ((longint'(cal_regs[REG_CAL_TCO]) * dt) >>> 7);
        sens = longint'(cal_regs[REG_CAL_SENS]) * 32768
             + ((longint'(cal_regs[REG_CAL_TCS]) * dt) >>> 8);
        // second-order correction when cold, extra term when very cold
        if (temp < 2000) begin
            sq    = (temp - 2000) * (temp - 2000);
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (temp < -1500) begin
                sq2   = (temp + 1500) * (temp + 1500);
                off2  = off2 + 7 * sq2;
                sens2 = sens2 + ((11 * sq2) >>> 1);
            end
            off  = off - off2;
            sens = sens - sens2;
        end
        p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        if (p < 0) p = 0;
        if (p > PRES_MAX) p = PRES_MAX;
        return PRES_W'(p);
    endfunction

    // Advance ground / filter state for one accepted item
    task automatic predict_altitude(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        logic [PRES_W-1:0] p;
        longint h;
        longint sum;
        p = comp_pressure(d1, d2);
        if (!ground_done) begin
            if (ground_count < N_GROUND) begin
                ground_level = GND_W'(ground_level + p);
                ground_count++;
            end else begin
                ground_level = GND_W'((longint'(ground_level) + N_GROUND / 2) / N_GROUND);
                ground_done  = 1'b1;
            end
            return;
        end
        h = (ground_level > p) ? ((longint'(ground_level - p) * HEIGHT_K) >> 8) : 0;
        for (int i = N_TAPS - 1; i > 0; i--) height_taps[i] = height_taps[i-1];
        height_taps[0] = ALT_W'(h);
        sum = 0;
        for (int i = 0; i < N_TAPS; i++) sum += height_taps[i];
        altitude_q.push_back(ALT_W'(sum / N_TAPS));
    endtask

    // Offer one item, with burst/gap idling on the sender side
    task automatic send_item(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {d2, d1};
        do @(posedge aclk); while (!s_tready);
        predict_altitude(d1, d2);
        items_sent++;
        if (--burst_left <= 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CAL_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < N_REGS) cal_regs[idx] = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Block is idle once nothing is expected and the last item has drained
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (altitude_q.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    task automatic load_cal(logic [CAL_W-1:0] c1, logic [CAL_W-1:0] c2,
                            logic [CAL_W-1:0] c3, logic [CAL_W-1:0] c4,
                            logic [CAL_W-1:0] c5, logic [CAL_W-1:0] c6);
        write_cal(REG_CAL_SENS, c1);
        write_cal(REG_CAL_OFFSET, c2);
        write_cal(REG_CAL_TCS, c3);
        write_cal(REG_CAL_TCO, c4);
        write_cal(REG_CAL_TREF, c5);
        write_cal(REG_CAL_TEMPSENS, c6);
    endtask

    // Mostly plausible sensor readings, the rest anywhere in range
    task automatic send_random(int n);
        logic [RAW_W-1:0] d1, d2;
        repeat (n) begin
            if ($urandom_range(0, 3) != 0) begin
                d1 = RAW_W'(9085466 - 400000 + $urandom_range(0, 800000));
                d2 = RAW_W'(6500000 + $urandom_range(0, 4000000));
            end else begin
                d1 = RAW_W'($urandom);
                d2 = RAW_W'($urandom);
            end
            if (items_sent == 500) hold_req = 1'b1;
            send_item(d1, d2);
        end
    endtask

    // Receiver: changing stall patterns plus one long hold-off
    initial begin
        int mode;
        m_tready = 1'b0;
        mode = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 1'b0;
            end
            if ((cycle_count % 64) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = $urandom_range(0, 1);
                default: m_tready = ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Output checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            alts_seen++;
            if (altitude_q.size() == 0) begin
                $error("unexpected altitude item: altitude_cm actual %0d", m_tdata[ALT_W-1:0]);
                err_count++;
            end else begin
                logic [ALT_W-1:0] want;
                want = altitude_q.pop_front();
                if (m_tdata[ALT_W-1:0] !== want) begin
                    $error("altitude_cm mismatch: expected %0d actual %0d",
                           want, m_tdata[ALT_W-1:0]);
                    err_count++;
                end
                if (m_tdata[TDATA_OUT_W-1:ALT_W] !== '0) begin
                    $error("m_tdata pad mismatch: expected 0 actual %0h",
                           m_tdata[TDATA_OUT_W-1:ALT_W]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("baro_altitude_estimator_unit_test NOT OK");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        err_count = 0;
        items_sent = 0;
        alts_seen = 0;
        burst_left = 8;
        hold_req = 1'b0;
        ground_count = 0;
        ground_done = 1'b0;
        ground_level = '0;
        foreach (cal_regs[i]) cal_regs[i] = '0;
        foreach (height_taps[i]) height_taps[i] = '0;

        // extremes and temperature bands; cold and very cold via low d2
        directed_rows = '{
            '{24'd0,        24'd0},        '{24'hFFFFFF,   24'hFFFFFF},
            '{24'd0,        24'hFFFFFF},   '{24'hFFFFFF,   24'd0},
            '{24'd9085466,  24'd8569150},  '{24'd9085466,  24'd8569150},
            '{24'd9085466,  24'd8000000},  '{24'd9085466,  24'd7000000},
            '{24'd9085466,  24'd0},        '{24'd8500000,  24'd8569150},
            '{24'd8000000,  24'd8569150},  '{24'd7000000,  24'd9500000},
            '{24'd9600000,  24'd8569150},  '{24'h555555,   24'hAAAAAA},
            '{24'hAAAAAA,   24'h555555},   '{24'd9085466,  24'd8566784},
            '{24'd9085466,  24'd8569150},  '{24'd9085466,  24'd8569150},
            '{24'd9085466,  24'd8569150},  '{24'd9085466,  24'd8569150}
        };

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // typical calibration; unknown indexes must be ignored
        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        write_cal(3'd6, 16'hFFFF);
        write_cal(3'd7, 16'hFFFF);

        // ground reference, then the directed rows
        send_random(N_GROUND + 1);
        foreach (directed_rows[i]) send_item(directed_rows[i].d1, directed_rows[i].d2);
        send_random(300);
        wait_drain();

        load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(100);
        wait_drain();

        load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_random(80);
        wait_drain();

        repeat (3) begin
            load_cal(CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom),
                     CAL_W'($urandom), CAL_W'($urandom), CAL_W'($urandom));
            send_random(100);
            wait_drain();
        end

        load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_random(100);
        wait_drain();

        $display("covered %0d input items and %0d altitude items over 7 calibration sets",
                 items_sent, alts_seen);
        if (err_count == 0 && altitude_q.size() == 0) begin
            $display("baro_altitude_estimator_unit_test OK");
        end else begin
            $display("baro_altitude_estimator_unit_test NOT OK");
        end
        $finish;
    end

endmodule
